// ----- rtl/clutd_pkg.sv -----
package clutd_pkg;

    localparam int OP_W       = 2;
    localparam int INDEX_W    = 8;
    localparam int COLOR_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int CHAN_W     = 8;
    localparam int OFF_W      = 19;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int PAL_DEPTH  = 1 << INDEX_W;
    localparam int NIB_W      = 4;
    localparam int FLD_W      = 5;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_TILE_LINES = 32;

    localparam int TILE_W_4BPP = 128;
    localparam int TILE_W_8BPP = 64;

    typedef logic [OP_W-1:0]      t_op;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_op OP_PAL_WR  = 2'd0;
    localparam t_op OP_DATA    = 2'd1;
    localparam t_op OP_RESTART = 2'd2;

    localparam t_cfg_idx CFG_MODE   = 2'd0;
    localparam t_cfg_idx CFG_WIDTH  = 2'd1;
    localparam t_cfg_idx CFG_HEIGHT = 2'd2;

    localparam logic                RST_MODE   = 1'b1;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd256;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 10'd256;

    // Position of the first pixel a data byte produces
    typedef struct packed {
        logic [HEIGHT_W-1:0] row;
        logic [WIDTH_W-1:0]  col;
        logic                done;
    } t_pos;

endpackage

// ----- rtl/clutd_pal.sv -----
module clutd_pal (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [clutd_pkg::INDEX_W-1:0]   i_waddr,
    input  logic [clutd_pkg::COLOR_W-1:0]   i_wdata,
    input  logic                            i_re,
    input  logic [clutd_pkg::INDEX_W-1:0]   i_raddr0,
    input  logic [clutd_pkg::INDEX_W-1:0]   i_raddr1,
    output logic [clutd_pkg::COLOR_W-1:0]   o_rdata0,
    output logic [clutd_pkg::COLOR_W-1:0]   o_rdata1
);
    import clutd_pkg::*;

    logic [COLOR_W-1:0] r_mem [PAL_DEPTH];
    logic [COLOR_W-1:0] r_rdata0;
    logic [COLOR_W-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata0 <= r_mem[i_raddr0];
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ----- rtl/clutd_pos.sv -----
module clutd_pos #(
    parameter int MAX_WIDTH  = clutd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = clutd_pkg::DEF_MAX_HEIGHT,
    parameter int TILE_LINES = clutd_pkg::DEF_TILE_LINES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [clutd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [clutd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_step,
    input  logic                              i_restart,
    output clutd_pkg::t_pos                   o_pos,
    output logic                              o_mode,
    output logic [clutd_pkg::WIDTH_W-1:0]     o_eff_width
);
    import clutd_pkg::*;

    localparam int LINE_W  = (TILE_LINES > 1) ? $clog2(TILE_LINES) : 1;
    localparam int PIX_W   = $clog2(TILE_W_4BPP);
    localparam int SH_8BPP = $clog2(TILE_W_8BPP);
    localparam int SH_4BPP = $clog2(TILE_W_4BPP);
    localparam int W_MAXV  = (1 << WIDTH_W) - 1;
    localparam int H_MAXV  = (1 << HEIGHT_W) - 1;
    localparam int W_CLIP  = (MAX_WIDTH > W_MAXV) ? W_MAXV : MAX_WIDTH;
    localparam int H_CLIP  = (MAX_HEIGHT > H_MAXV) ? H_MAXV : MAX_HEIGHT;

    logic                r_mode;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [HEIGHT_W-1:0] r_row_base;
    logic [WIDTH_W-1:0]  r_col_base;
    logic [LINE_W-1:0]   r_line;
    logic [PIX_W-1:0]    r_pix;

    logic [HEIGHT_W-1:0] n_row_base;
    logic [WIDTH_W-1:0]  n_col_base;
    logic [LINE_W-1:0]   n_line;
    logic [PIX_W-1:0]    n_pix;

    logic [WIDTH_W-1:0]  w_sat;
    logic [WIDTH_W-1:0]  w_round;
    logic [WIDTH_W-1:0]  tile_w;
    logic [WIDTH_W-1:0]  eff_w;
    logic [HEIGHT_W-1:0] h_sat;
    logic [PIX_W-1:0]    inc;
    logic                wrap_line;
    logic                wrap_tile;
    logic                wrap_col;
    logic                row_end;
    logic                done;
    logic                cfg_hit;

    always_comb begin
        w_sat   = (r_width > WIDTH_W'(W_CLIP)) ? WIDTH_W'(W_CLIP) : r_width;
        w_round = r_mode ? {w_sat[WIDTH_W-1:SH_8BPP], {SH_8BPP{1'b0}}}
                         : {w_sat[WIDTH_W-1:SH_4BPP], {SH_4BPP{1'b0}}};
        tile_w  = r_mode ? WIDTH_W'(TILE_W_8BPP) : WIDTH_W'(TILE_W_4BPP);
        eff_w   = (w_round == '0) ? tile_w : w_round;
        h_sat   = (r_height > HEIGHT_W'(H_CLIP)) ? HEIGHT_W'(H_CLIP) : r_height;
        inc     = r_mode ? PIX_W'(1) : PIX_W'(2);

        wrap_line = ({1'b0, r_pix} + {1'b0, inc}) >= (PIX_W+1)'(tile_w);
        wrap_tile = wrap_line && (r_line == LINE_W'(TILE_LINES - 1));
        wrap_col  = wrap_tile && (({1'b0, r_col_base} + {1'b0, tile_w}) >= {1'b0, eff_w});
        // row base is a multiple of the tile height, so comparing it plus two
        // tiles with the saturated height replaces rounding the height down
        row_end   = ({1'b0, r_row_base} + (HEIGHT_W+1)'(2 * TILE_LINES)) > {1'b0, h_sat};
        done      = wrap_col && row_end;

        n_row_base = r_row_base;
        n_col_base = r_col_base;
        n_line     = r_line;
        n_pix      = r_pix;
        if (!wrap_line) begin
            n_pix = r_pix + inc;
        end else begin
            n_pix = '0;
            if (!wrap_tile) begin
                n_line = r_line + LINE_W'(1);
            end else begin
                n_line = '0;
                if (!wrap_col) begin
                    n_col_base = r_col_base + tile_w;
                end else begin
                    n_col_base = '0;
                    n_row_base = done ? '0 : r_row_base + HEIGHT_W'(TILE_LINES);
                end
            end
        end
    end

    assign cfg_hit = i_cfg_we && ((i_cfg_idx == CFG_MODE) || (i_cfg_idx == CFG_WIDTH) ||
                                  (i_cfg_idx == CFG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= RST_MODE;
            r_width    <= RST_WIDTH;
            r_height   <= RST_HEIGHT;
            r_row_base <= '0;
            r_col_base <= '0;
            r_line     <= '0;
            r_pix      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:   r_mode   <= i_cfg_data[0];
                    CFG_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (cfg_hit || i_restart) begin
                r_row_base <= '0;
                r_col_base <= '0;
                r_line     <= '0;
                r_pix      <= '0;
            end else if (i_step) begin
                r_row_base <= n_row_base;
                r_col_base <= n_col_base;
                r_line     <= n_line;
                r_pix      <= n_pix;
            end
        end
    end

    assign o_pos.row   = r_row_base + HEIGHT_W'(r_line);
    assign o_pos.col   = r_col_base + WIDTH_W'(r_pix);
    assign o_pos.done  = done;
    assign o_mode      = r_mode;
    assign o_eff_width = eff_w;

endmodule

// ----- rtl/clut_texture_tile_decoder_core.sv -----
// Palettized texture decoder. Load palette words (operation 0) before any data
// byte that looks them up: entries are not cleared at reset and an unwritten
// entry reads as garbage. Each data byte (operation 1) gives one RGBA pixel in
// 8-bit mode or two in 4-bit mode (low nibble first), tagged with its raster
// offset; operation 2 restarts the tile walk, and any register write does too.
// Data bytes pass stage A, stage B and the output register. With i_out_ready
// high one pixel leaves per cycle: a byte per cycle in 8-bit mode, while in
// 4-bit mode a byte holds stage B until both pixels leave. Palette writes and
// restarts go one beat per cycle unless a byte waits in stage A. The palette
// is a 256-entry memory with two registered read ports, read once per byte.
module clut_texture_tile_decoder_core #(
    parameter int MAX_WIDTH  = clutd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = clutd_pkg::DEF_MAX_HEIGHT,
    parameter int TILE_LINES = clutd_pkg::DEF_TILE_LINES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [clutd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [clutd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [clutd_pkg::OP_W-1:0]        i_operation,
    input  logic [clutd_pkg::INDEX_W-1:0]     i_palette_index,
    input  logic [clutd_pkg::COLOR_W-1:0]     i_palette_color,
    input  logic [clutd_pkg::BYTE_W-1:0]      i_data_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [clutd_pkg::OFF_W-1:0]       o_pixel_offset,
    output logic [clutd_pkg::CHAN_W-1:0]      o_red,
    output logic [clutd_pkg::CHAN_W-1:0]      o_green,
    output logic [clutd_pkg::CHAN_W-1:0]      o_blue,
    output logic [clutd_pkg::CHAN_W-1:0]      o_alpha,
    output logic                              o_last_of_run,
    output logic                              o_image_done
);
    import clutd_pkg::*;

    localparam int PROD_W = HEIGHT_W + WIDTH_W;
    localparam int PAD_W  = CHAN_W - FLD_W;

    t_pos                pos;
    logic                mode;
    logic [WIDTH_W-1:0]  eff_w;

    logic                in_fire;
    logic                load_a;
    logic                a_adv;
    logic                b_go;
    logic                b_free;
    logic                b_emit;
    logic                b_last;
    logic                b_pop;
    logic                c_free;
    logic [PROD_W-1:0]   prod;
    logic [INDEX_W-1:0]  raddr0;
    logic [INDEX_W-1:0]  raddr1;
    logic [COLOR_W-1:0]  word0;
    logic [COLOR_W-1:0]  word1;
    logic [COLOR_W-1:0]  word_sel;

    // stage A: accepted palette writes and data bytes
    logic                r_a_vld;
    logic                r_a_wr;
    logic [INDEX_W-1:0]  r_a_pidx;
    logic [COLOR_W-1:0]  r_a_pcol;
    logic [BYTE_W-1:0]   r_a_byte;
    logic                r_a_mode;
    t_pos                r_a_pos;

    // stage B: palette words and offset of one byte
    logic                r_b_vld;
    logic                r_b_mode;
    logic                r_b_phase;
    logic                r_b_done;
    logic [OFF_W-1:0]    r_b_off;

    // output register
    logic                r_o_vld;
    logic [OFF_W-1:0]    r_o_off;
    logic [CHAN_W-1:0]   r_o_red;
    logic [CHAN_W-1:0]   r_o_green;
    logic [CHAN_W-1:0]   r_o_blue;
    logic [CHAN_W-1:0]   r_o_alpha;
    logic                r_o_last;
    logic                r_o_done;

    clutd_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .TILE_LINES (TILE_LINES)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_step      (in_fire && (i_operation == OP_DATA)),
        .i_restart   (in_fire && (i_operation == OP_RESTART)),
        .o_pos       (pos),
        .o_mode      (mode),
        .o_eff_width (eff_w)
    );

    clutd_pal u_pal (
        .i_clk    (i_clk),
        .i_we     (a_adv && r_a_wr),
        .i_waddr  (r_a_pidx),
        .i_wdata  (r_a_pcol),
        .i_re     (b_go),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (word0),
        .o_rdata1 (word1)
    );

    assign c_free = !r_o_vld || i_out_ready;
    assign b_last = r_b_mode || r_b_phase;
    assign b_emit = r_b_vld && c_free;
    assign b_pop  = b_emit && b_last;
    assign b_free = !r_b_vld || b_pop;
    // palette writes leave stage A in order with reads, so a byte never sees
    // a palette word written after it
    assign a_adv  = r_a_vld && (r_a_wr || b_free);
    assign b_go   = a_adv && !r_a_wr;

    assign o_in_ready = !r_a_vld || a_adv;
    assign in_fire    = i_in_valid && o_in_ready;
    assign load_a     = in_fire && ((i_operation == OP_DATA) || (i_operation == OP_PAL_WR));

    assign raddr0   = r_a_mode ? r_a_byte : {{(INDEX_W-NIB_W){1'b0}}, r_a_byte[NIB_W-1:0]};
    assign raddr1   = {{(INDEX_W-NIB_W){1'b0}}, r_a_byte[BYTE_W-1:NIB_W]};
    assign prod     = PROD_W'(r_a_pos.row) * PROD_W'(eff_w);
    assign word_sel = r_b_phase ? word1 : word0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (load_a) begin
            r_a_vld <= 1'b1;
        end else if (a_adv) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_wr   <= (i_operation == OP_PAL_WR);
            r_a_pidx <= i_palette_index;
            r_a_pcol <= i_palette_color;
            r_a_byte <= i_data_byte;
            r_a_mode <= mode;
            r_a_pos  <= pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_b_phase <= 1'b0;
        end else begin
            if (b_go) begin
                r_b_vld   <= 1'b1;
                r_b_phase <= 1'b0;
            end else if (b_pop) begin
                r_b_vld <= 1'b0;
            end else if (b_emit) begin
                r_b_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_b_mode <= r_a_mode;
            r_b_done <= r_a_pos.done;
            r_b_off  <= OFF_W'(prod + PROD_W'(r_a_pos.col));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (b_emit) begin
            r_o_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_emit) begin
            r_o_off   <= r_b_off + OFF_W'(r_b_phase);
            r_o_red   <= {word_sel[FLD_W-1:0], {PAD_W{1'b0}}};
            r_o_green <= {word_sel[2*FLD_W-1:FLD_W], {PAD_W{1'b0}}};
            r_o_blue  <= {word_sel[3*FLD_W-1:2*FLD_W], {PAD_W{1'b0}}};
            r_o_alpha <= (word_sel == '0) ? '0 : '1;
            r_o_last  <= b_last;
            r_o_done  <= r_b_done && b_last;
        end
    end

    assign o_out_valid    = r_o_vld;
    assign o_pixel_offset = r_o_off;
    assign o_red          = r_o_red;
    assign o_green        = r_o_green;
    assign o_blue         = r_o_blue;
    assign o_alpha        = r_o_alpha;
    assign o_last_of_run  = r_o_last;
    assign o_image_done   = r_o_done;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_image_done |-> o_last_of_run)
        else $error("image end flagged on a pixel that does not end its byte");

    a_second_pixel_only_4bpp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld && r_b_phase |-> !r_b_mode)
        else $error("second pixel of a byte in 8-bit mode");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_run |=>
            o_out_valid && (o_pixel_offset == OFF_W'($past(o_pixel_offset) + OFF_W'(1))))
        else $error("high nibble pixel did not follow its low nibble pixel");

    a_write_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && r_a_wr |-> o_in_ready)
        else $error("palette write held up in stage A");

endmodule
